[sv/pci_class_match_scanner_top_macros.svh]
// assertion helpers for the checker file
`ifndef PCI_CLASS_MATCH_SCANNER_TOP_MACROS_SVH
`define PCI_CLASS_MATCH_SCANNER_TOP_MACROS_SVH

// same-cycle implication, off while reset is high
`define PCMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcms check failed");

// next-cycle implication, off while reset is high
`define PCMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcms check failed");

`endif

[sv/pcms_pkg.sv]
package pcms_pkg;

   // scan size
   localparam int BUS_COUNT     = 256;
   localparam int MAX_FUNCTIONS = 8;

   localparam logic [7:0] LAST_BUS      = 8'(BUS_COUNT - 1);
   localparam logic [4:0] LAST_DEVICE   = 5'd31;
   localparam logic [2:0] LAST_FUNCTION = 3'(MAX_FUNCTIONS - 1);

   // result kinds
   localparam logic [1:0] KIND_READ    = 2'd0;
   localparam logic [1:0] KIND_FOUND   = 2'd1;
   localparam logic [1:0] KIND_NONE    = 2'd2;
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   // request commands
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_TARGET_CLASS    = 2'd0;
   localparam logic [1:0] CSR_TARGET_SUBCLASS = 2'd1;
   localparam logic [1:0] CSR_TARGET_PROGIF   = 2'd2;

   // register reset values
   localparam logic [7:0] RESET_CLASS    = 8'h01;
   localparam logic [7:0] RESET_SUBCLASS = 8'h06;
   localparam logic [7:0] RESET_PROGIF   = 8'h01;

   // config space dword offsets
   localparam logic [7:0] OFFSET_ID     = 8'h00;
   localparam logic [7:0] OFFSET_CLASS  = 8'h08;
   localparam logic [7:0] OFFSET_HEADER = 8'h0C;

   localparam logic [15:0] VENDOR_ABSENT = 16'hFFFF;

   typedef enum logic [2:0] {
      PHASE_ID     = 3'b001,
      PHASE_CLASS  = 3'b010,
      PHASE_HEADER = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0]  header_byte;
      logic [7:0]  progif_byte;
      logic [7:0]  subclass_byte;
      logic [7:0]  class_byte;
      logic [15:0] device_ident;
      logic [15:0] vendor_ident;
      logic [2:0]  found_function;
      logic [4:0]  found_device;
      logic [7:0]  found_bus;
      logic [31:0] cfg_address;
   } rsp_payload_type;

   localparam int RSP_DATA_W = $bits(rsp_payload_type);

   // mechanism #1 address: enable, bus, device, function, dword offset
   function automatic logic [31:0] make_address(input logic [7:0] bus,
                                                input logic [4:0] dev,
                                                input logic [2:0] fn,
                                                input logic [7:0] offset);
      make_address = {1'b1, 7'd0, bus, dev, fn, offset & 8'hFC};
   endfunction

endpackage

[sv/pci_class_match_scanner_top.sv]
// pci class match scanner: brute-force walk of every bus, device and function through
// configuration mechanism #1 addresses, stopping at the first function whose class,
// subclass and programming interface equal the three target registers. a start request
// (tuser 0) resets the walk to bus 0 device 0 function 0 and answers with the first read
// address; each data request (tuser 1) carries the dword read at the last address and
// answers with exactly one response: the next read address (kind 0), the match with its
// location, ids, class bytes and header type (kind 1), none found after the last bus
// (kind 2), or ignored when no scan is running (kind 3). a request is accepted every
// cycle while the response side is not stalled; its response passes through the input
// register and the response register with one level of compare and increment logic
// between them. the input register can still take one request while a response is
// stalled downstream. targets may be rewritten only while no scan is in flight.
module pci_class_match_scanner_top (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // read_data
   input  logic                           req_tuser,   // cmd
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // cfg_address, found_bus, found_device, found_function, vendor_ident,
   // device_ident, class_byte, subclass_byte, progif_byte, header_byte
   output logic [pcms_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                     rsp_tuser,   // kind
   // target registers
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [7:0]                     csr_wdata
);
   import pcms_pkg::*;

   // target registers
   logic [7:0] target_class_ff, target_subclass_ff, target_progif_ff;

   // input stage
   logic        in_valid_ff;
   logic        in_cmd_ff;
   logic [31:0] in_data_ff;

   // scan state
   logic        busy_ff, busy_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  bus_ff, bus_in;
   logic [4:0]  dev_ff, dev_in;
   logic [2:0]  fn_ff, fn_in;
   logic        multi_ff, multi_in;
   logic [31:0] id_ff, id_in;
   logic [23:0] class_ff, class_in;

   // response stage
   logic            rsp_valid_ff;
   logic [1:0]      rsp_kind_ff, rsp_kind_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // step control
   logic       step;        // input stage moves into the response register
   logic       out_free;    // response register can take a new value
   logic       go_fn;       // move on to the next function
   logic       go_dev;      // move on to the next device
   logic       more;        // another function remains to probe
   logic [7:0] header;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign header   = in_data_ff[23:16];

   always_comb begin
      busy_in     = busy_ff;
      phase_in    = phase_ff;
      bus_in      = bus_ff;
      dev_in      = dev_ff;
      fn_in       = fn_ff;
      multi_in    = multi_ff;
      id_in       = id_ff;
      class_in    = class_ff;
      rsp_kind_in = KIND_READ;
      rsp_data_in = '0;
      go_fn       = 1'b0;
      go_dev      = 1'b0;
      more        = 1'b0;

      if (in_cmd_ff == CMD_START) begin
         // start or restart from the very first function
         busy_in                 = 1'b1;
         phase_in                = PHASE_ID;
         bus_in                  = '0;
         dev_in                  = '0;
         fn_in                   = '0;
         multi_in                = 1'b0;
         rsp_data_in.cfg_address = make_address('0, '0, '0, OFFSET_ID);
      end else if (!busy_ff) begin
         rsp_kind_in = KIND_IGNORED;
      end else begin
         case (phase_ff)
            PHASE_CLASS: begin
               class_in                = in_data_ff[31:8];
               phase_in                = PHASE_HEADER;
               rsp_data_in.cfg_address = make_address(bus_ff, dev_ff, fn_ff, OFFSET_HEADER);
            end
            PHASE_HEADER: begin
               if (fn_ff == 3'd0) begin
                  multi_in = header[7];
               end
               if (class_ff[23:16] == target_class_ff &&
                   class_ff[15:8]  == target_subclass_ff &&
                   class_ff[7:0]   == target_progif_ff) begin
                  busy_in                    = 1'b0;
                  phase_in                   = PHASE_ID;
                  rsp_kind_in                = KIND_FOUND;
                  rsp_data_in.found_bus      = bus_ff;
                  rsp_data_in.found_device   = dev_ff;
                  rsp_data_in.found_function = fn_ff;
                  rsp_data_in.vendor_ident   = id_ff[15:0];
                  rsp_data_in.device_ident   = id_ff[31:16];
                  rsp_data_in.class_byte     = class_ff[23:16];
                  rsp_data_in.subclass_byte  = class_ff[15:8];
                  rsp_data_in.progif_byte    = class_ff[7:0];
                  rsp_data_in.header_byte    = header;
               end else begin
                  go_fn = 1'b1;
               end
            end
            default: begin
               // id dword; an absent vendor on function 0 drops the whole device
               id_in = in_data_ff;
               if (in_data_ff[15:0] == VENDOR_ABSENT) begin
                  if (fn_ff == 3'd0) begin
                     go_dev = 1'b1;
                  end else begin
                     go_fn = 1'b1;
                  end
               end else begin
                  phase_in                = PHASE_CLASS;
                  rsp_data_in.cfg_address = make_address(bus_ff, dev_ff, fn_ff, OFFSET_CLASS);
               end
            end
         endcase
      end

      // next function within the device, else fall through to the next device;
      // function 0's header bit 7 opens functions 1 and up
      if (go_fn) begin
         if (multi_in && fn_ff != LAST_FUNCTION) begin
            fn_in = fn_ff + 3'd1;
            more  = 1'b1;
         end else begin
            go_dev = 1'b1;
         end
      end

      // next device, wrapping into the next bus
      if (go_dev) begin
         fn_in    = '0;
         multi_in = 1'b0;
         if (dev_ff != LAST_DEVICE) begin
            dev_in = dev_ff + 5'd1;
            more   = 1'b1;
         end else begin
            dev_in = '0;
            if (bus_ff != LAST_BUS) begin
               bus_in = bus_ff + 8'd1;
               more   = 1'b1;
            end else begin
               bus_in = '0;
            end
         end
      end

      // issue the id read of the new function, or report the end of the walk
      if (go_fn || go_dev) begin
         phase_in = PHASE_ID;
         if (more) begin
            rsp_data_in.cfg_address = make_address(bus_in, dev_in, fn_in, OFFSET_ID);
         end else begin
            busy_in     = 1'b0;
            rsp_kind_in = KIND_NONE;
         end
      end
   end

   // target registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_class_ff    <= RESET_CLASS;
         target_subclass_ff <= RESET_SUBCLASS;
         target_progif_ff   <= RESET_PROGIF;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_CLASS:    target_class_ff    <= csr_wdata;
            CSR_TARGET_SUBCLASS: target_subclass_ff <= csr_wdata;
            CSR_TARGET_PROGIF:   target_progif_ff   <= csr_wdata;
            default: ;  // writes past the last register are dropped
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_data_ff <= req_tdata;
      end
   end

   // scan state advances once per request handed to the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PHASE_ID;
         bus_ff   <= '0;
         dev_ff   <= '0;
         fn_ff    <= '0;
         multi_ff <= 1'b0;
         id_ff    <= '0;
         class_ff <= '0;
      end else if (step) begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         bus_ff   <= bus_in;
         dev_ff   <= dev_in;
         fn_ff    <= fn_in;
         multi_ff <= multi_in;
         id_ff    <= id_in;
         class_ff <= class_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[sv/pcms_checker.sv]
`include "pci_class_match_scanner_top_macros.svh"

module pcms_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pcms_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                     rsp_tuser
);
   import pcms_pkg::*;

   // a stalled response holds
   `PCMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a read request carries the enable bit and a dword-aligned offset
   `PCMS_ASSERT_NOW(a_read_addr, clock, reset, rsp_tvalid && rsp_tuser == KIND_READ, rsp_tdata[31] && rsp_tdata[1:0] == 2'b00 && (rsp_tdata[7:0] == OFFSET_ID || rsp_tdata[7:0] == OFFSET_CLASS || rsp_tdata[7:0] == OFFSET_HEADER))

   // only read requests carry an address
   `PCMS_ASSERT_NOW(a_addr_zero, clock, reset, rsp_tvalid && rsp_tuser != KIND_READ, rsp_tdata[31:0] == 32'd0)

   // only a match carries the function description
   `PCMS_ASSERT_NOW(a_found_zero, clock, reset, rsp_tvalid && rsp_tuser != KIND_FOUND, rsp_tdata[RSP_DATA_W-1:32] == '0)

endmodule

bind pci_class_match_scanner_top pcms_checker u_pcms_checker (.*);

[bench/pci_class_match_scanner_top_tb.sv]
`timescale 1ns / 1ps

module pci_class_match_scanner_top_tb;
   import pcms_pkg::*;

   // one expected response: kind plus the packed payload of the response bus
   typedef struct packed {
      logic [1:0]      kind;
      rsp_payload_type body;
   } scan_answer_type;

   // quiet cycles (nothing accepted on either side) before the run is declared hung
   localparam int QUIET_LIMIT = 3000;

   // tracks the scan walk and holds the responses still owed by the block
   class scan_scoreboard;
      logic [7:0]   want_class;
      logic [7:0]   want_subclass;
      logic [7:0]   want_progif;
      logic         busy;
      phase_type    phase;
      logic [7:0]   bus_no;
      logic [4:0]   dev_no;
      logic [2:0]   fn_no;
      logic         multi_fn;
      logic [31:0]  id_dword;
      logic [23:0]  class_bits;
      scan_answer_type awaited_answers[$];
      int unsigned  fail_count;

      function new();
         want_class    = RESET_CLASS;
         want_subclass = RESET_SUBCLASS;
         want_progif   = RESET_PROGIF;
         busy          = 1'b0;
         phase         = PHASE_ID;
         bus_no        = '0;
         dev_no        = '0;
         fn_no         = '0;
         multi_fn      = 1'b0;
         id_dword      = '0;
         class_bits    = '0;
         fail_count    = 0;
      endfunction

      function logic [31:0] addr_of(input logic [7:0] offset);
         return {1'b1, 7'd0, bus_no, dev_no, fn_no, offset[7:2], 2'b00};
      endfunction

      // next device; zero once the last bus is done
      function bit step_device();
         fn_no    = '0;
         multi_fn = 1'b0;
         if (dev_no != LAST_DEVICE) begin
            dev_no++;
            return 1'b1;
         end
         dev_no = '0;
         if (bus_no != LAST_BUS) begin
            bus_no++;
            return 1'b1;
         end
         bus_no = '0;
         return 1'b0;
      endfunction

      function bit step_function();
         if (multi_fn && fn_no != LAST_FUNCTION) begin
            fn_no++;
            return 1'b1;
         end
         return step_device();
      endfunction

      // id read of the new function, or none found when the walk ran out
      function void advance(input bit more, inout scan_answer_type ans);
         phase = PHASE_ID;
         if (more) begin
            ans.kind             = KIND_READ;
            ans.body.cfg_address = addr_of(OFFSET_ID);
         end else begin
            busy     = 1'b0;
            ans.kind = KIND_NONE;
         end
      endfunction

      function void note_request(input logic cmd, input logic [31:0] data);
         scan_answer_type ans;
         logic [7:0]   header;
         bit           more;
         ans = '0;
         if (cmd == CMD_START) begin
            busy     = 1'b1;
            phase    = PHASE_ID;
            bus_no   = '0;
            dev_no   = '0;
            fn_no    = '0;
            multi_fn = 1'b0;
            ans.kind             = KIND_READ;
            ans.body.cfg_address = addr_of(OFFSET_ID);
         end else if (!busy) begin
            ans.kind = KIND_IGNORED;
         end else begin
            case (phase)
               PHASE_CLASS: begin
                  class_bits           = data[31:8];
                  phase                = PHASE_HEADER;
                  ans.kind             = KIND_READ;
                  ans.body.cfg_address = addr_of(OFFSET_HEADER);
               end
               PHASE_HEADER: begin
                  header = data[23:16];
                  if (fn_no == 0) multi_fn = header[7];
                  if (class_bits == {want_class, want_subclass, want_progif}) begin
                     busy  = 1'b0;
                     phase = PHASE_ID;
                     ans.kind                = KIND_FOUND;
                     ans.body.found_bus      = bus_no;
                     ans.body.found_device   = dev_no;
                     ans.body.found_function = fn_no;
                     ans.body.vendor_ident   = id_dword[15:0];
                     ans.body.device_ident   = id_dword[31:16];
                     ans.body.class_byte     = class_bits[23:16];
                     ans.body.subclass_byte  = class_bits[15:8];
                     ans.body.progif_byte    = class_bits[7:0];
                     ans.body.header_byte    = header;
                  end else begin
                     more = step_function();
                     advance(more, ans);
                  end
               end
               default: begin
                  id_dword = data;
                  if (data[15:0] == VENDOR_ABSENT) begin
                     // absent function 0 drops the whole device
                     more = (fn_no == 0) ? step_device() : step_function();
                     advance(more, ans);
                  end else begin
                     phase                = PHASE_CLASS;
                     ans.kind             = KIND_READ;
                     ans.body.cfg_address = addr_of(OFFSET_CLASS);
                  end
               end
            endcase
         end
         awaited_answers.push_back(ans);
      endfunction

      task report(input string msg);
         fail_count++;
         if (fail_count <= 50) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
         if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
      endtask

      task check_response(input logic [1:0] kind, input rsp_payload_type got);
         scan_answer_type want;
         if (awaited_answers.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = awaited_answers.pop_front();
         compare_field("kind", kind, want.kind);
         compare_field("cfg_address", got.cfg_address, want.body.cfg_address);
         compare_field("found_bus", got.found_bus, want.body.found_bus);
         compare_field("found_device", got.found_device, want.body.found_device);
         compare_field("found_function", got.found_function, want.body.found_function);
         compare_field("vendor_ident", got.vendor_ident, want.body.vendor_ident);
         compare_field("device_ident", got.device_ident, want.body.device_ident);
         compare_field("class_byte", got.class_byte, want.body.class_byte);
         compare_field("subclass_byte", got.subclass_byte, want.body.subclass_byte);
         compare_field("progif_byte", got.progif_byte, want.body.progif_byte);
         compare_field("header_byte", got.header_byte, want.body.header_byte);
      endtask
   endclass

   // dut connections, all inputs known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;
   logic                  req_tuser  = CMD_START;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [1:0]            csr_index  = CSR_TARGET_CLASS;
   logic [7:0]            csr_wdata  = '0;

   scan_scoreboard sb;

   // percent of cycles in which each side holds off
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int quiet_cycles  = 0;

   pci_class_match_scanner_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver backpressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // sample both channels at the rising edge; check before noting so a stray
   // response can never pair with a request taken in the same cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
      end
   end

   // hang detector: ends the run after too long with no handshake at all
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge; returns at the falling edge after the handshake
   // with valid still high, so a back-to-back request keeps it up
   task automatic send_request(input logic cmd, input logic [31:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // plays the part of config space: shapes the dword to the read the walk
   // is waiting for, with some starts and random dwords thrown in as noise
   task automatic feed_scan(input int absent_pct, input int match_pct, input int noise_pct);
      logic        cmd;
      logic [31:0] word;
      logic [23:0] target;
      cmd    = CMD_DATA;
      word   = $urandom;
      target = {sb.want_class, sb.want_subclass, sb.want_progif};
      if ($urandom_range(99) < noise_pct) begin
         if ($urandom_range(1) == 0) cmd = CMD_START;
      end else if (!sb.busy) begin
         // mostly a fresh scan, sometimes data nobody asked for
         if ($urandom_range(99) < 80) cmd = CMD_START;
      end else begin
         case (sb.phase)
            PHASE_ID: begin
               if ($urandom_range(99) < absent_pct) word[15:0] = VENDOR_ABSENT;
               else if (word[15:0] == VENDOR_ABSENT) word[0] = 1'b0;
            end
            PHASE_CLASS: begin
               if ($urandom_range(99) < match_pct) word[31:8] = target;
               else if (word[31:8] == target) word[8] = ~word[8];
            end
            default: begin
               // header dword left random: bit 23 decides multi-function
            end
         endcase
      end
      send_request(cmd, word);
   endtask

   // run the current scan to a match so the block is idle, then drain
   task automatic settle();
      while (sb.busy) feed_scan(0, 100, 0);
      req_tvalid <= 1'b0;
      while (sb.awaited_answers.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // called at a falling edge with the block idle
   task automatic write_targets(input logic [7:0] cls, input logic [7:0] sub,
                                input logic [7:0] pif);
      csr_we    <= 1'b1;
      csr_index <= CSR_TARGET_CLASS;
      csr_wdata <= cls;
      @(negedge clock);
      csr_index <= CSR_TARGET_SUBCLASS;
      csr_wdata <= sub;
      @(negedge clock);
      csr_index <= CSR_TARGET_PROGIF;
      csr_wdata <= pif;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.want_class    = cls;
      sb.want_subclass = sub;
      sb.want_progif   = pif;
   endtask

   initial begin
      sb = new();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver mostly stalled
      send_idle_pct = 16;
      rsp_idle_pct  = 86;

      // directed walk with the reset targets
      send_request(CMD_DATA, 32'h0000_0000);   // data while idle, ignored
      send_request(CMD_DATA, 32'hFFFF_FFFF);   // ignored, all ones
      send_request(CMD_START, 32'h0000_0000);
      send_request(CMD_DATA, 32'hFFFF_FFFF);   // function 0 absent, skip device
      send_request(CMD_DATA, 32'h1234_8086);
      send_request(CMD_DATA, 32'h0000_0000);   // class all zero, no match
      send_request(CMD_DATA, 32'h0080_0000);   // multi-function header
      send_request(CMD_DATA, 32'h0000_FFFF);   // function 1 absent, skip function
      send_request(CMD_DATA, 32'hABCD_0000);   // vendor zero
      send_request(CMD_DATA, 32'h0106_01FF);   // matching class bytes
      send_request(CMD_DATA, 32'hFF7F_FFFF);   // header, match reported
      send_request(CMD_DATA, 32'h5555_5555);   // idle again, ignored
      send_request(CMD_START, 32'hFFFF_FFFF);
      send_request(CMD_DATA, 32'hFFFE_FFFE);   // vendor one below absent
      send_request(CMD_START, 32'h0000_0000);  // restart while busy
      send_request(CMD_DATA, 32'h0001_1AF4);
      send_request(CMD_DATA, 32'hFFFF_FFFF);   // class all ones, no match
      send_request(CMD_DATA, 32'h0000_0000);   // single-function header
      send_request(CMD_DATA, 32'h0000_1AF4);
      send_request(CMD_DATA, 32'h0106_0100);
      send_request(CMD_DATA, 32'hFFFF_FFFF);   // header all ones, match reported
      settle();

      // random scans across target settings, extremes first
      write_targets(8'h00, 8'h00, 8'h00);
      repeat (275) feed_scan(30, 15, 5);
      settle();
      write_targets(8'hFF, 8'hFF, 8'hFF);
      repeat (275) feed_scan(30, 15, 5);
      settle();

      // sender mostly idle, receiver mostly ready
      send_idle_pct = 86;
      rsp_idle_pct  = 16;
      write_targets(8'($urandom), 8'($urandom), 8'($urandom));
      repeat (275) feed_scan(40, 20, 5);
      settle();
      write_targets(RESET_CLASS, RESET_SUBCLASS, RESET_PROGIF);
      repeat (275) feed_scan(20, 10, 8);
      settle();

      // full rate on both sides
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      write_targets(8'($urandom), 8'($urandom), 8'($urandom));
      repeat (550) feed_scan(30, 15, 5);
      settle();

      repeat (8) @(posedge clock);
      if (sb.fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

[pci_class_match_scanner_top.f]
+incdir+sv
sv/pcms_pkg.sv
sv/pci_class_match_scanner_top.sv
sv/pcms_checker.sv
bench/pci_class_match_scanner_top_tb.sv
